### design/leh_pkg.sv
`timescale 1ns / 1ps

package leh_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] CH_NL = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
  localparam logic [BYTE_W-1:0] CH_SP = 8'h20;

  localparam logic [BYTE_W-1:0] RST_BACKSPACE = 8'h08;
  localparam logic [BYTE_W-1:0] RST_ENTER     = 8'h0D;
  localparam logic [BYTE_W-1:0] RST_UP        = 8'h10;
  localparam logic [BYTE_W-1:0] RST_DOWN      = 8'h11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BACKSPACE,
    REG_ENTER,
    REG_UP,
    REG_DOWN
  } reg_idx_t;

  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_ENTER,
    CMD_BACK,
    CMD_UP,
    CMD_DOWN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_line_byte;
    logic              line_end;
    logic              last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NL,
    ST_LINE,
    ST_ERASE1,
    ST_ERASE2,
    ST_ERASE3,
    ST_LOOKUP,
    ST_FETCH,
    ST_TEXT,
    ST_CHAR
  } back_state_t;

endpackage

### design/leh_fifo.sv
`timescale 1ns / 1ps

module leh_fifo #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue fill count past depth");
`endif

endmodule

### design/leh_front.sv
`timescale 1ns / 1ps

module leh_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [leh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [leh_pkg::BYTE_W-1:0]     cfg_data,
  input  logic                           in_push,
  input  logic [leh_pkg::BYTE_W-1:0]     in_key_byte,
  output logic                           in_full,
  output logic                           cmd_push,
  output leh_pkg::cmd_t                  cmd,
  input  logic                           cmd_full
);

  import leh_pkg::*;

  logic [BYTE_W-1:0] bs_code_r, enter_code_r, up_code_r, down_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_code_r    <= RST_BACKSPACE;
      enter_code_r <= RST_ENTER;
      up_code_r    <= RST_UP;
      down_code_r  <= RST_DOWN;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BACKSPACE: bs_code_r    <= cfg_data;
        REG_ENTER:     enter_code_r <= cfg_data;
        REG_UP:        up_code_r    <= cfg_data;
        REG_DOWN:      down_code_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // enter beats backspace, backspace beats up, up beats down
  always_comb begin
    cmd.key = in_key_byte;
    if (in_key_byte == enter_code_r) begin
      cmd.kind = CMD_ENTER;
    end else if (in_key_byte == bs_code_r) begin
      cmd.kind = CMD_BACK;
    end else if (in_key_byte == up_code_r) begin
      cmd.kind = CMD_UP;
    end else if (in_key_byte == down_code_r) begin
      cmd.kind = CMD_DOWN;
    end else begin
      cmd.kind = CMD_CHAR;
    end
  end

  assign in_full  = cmd_full;
  assign cmd_push = in_push && !cmd_full;

endmodule

### design/leh_back.sv
`timescale 1ns / 1ps

module leh_back #(
  parameter int HISTORY_DEPTH = 16,
  parameter int LINE_BYTES    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  input  leh_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output leh_pkg::res_t res
);

  import leh_pkg::*;

  localparam int LEN_W      = $clog2(LINE_BYTES);
  localparam int SLOT_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int HMEM_DEPTH = HISTORY_DEPTH << LEN_W;

  back_state_t state_r, state_nxt;

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [SLOT_W-1:0] ws_r, ws_nxt;
  logic [CNT_W-1:0]  stored_r, stored_nxt;
  logic [CNT_W-1:0]  rp_r, rp_nxt;          // recall depth in lines back, zero on a new line
  logic [LEN_W-1:0]  ecnt_r, ecnt_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  rlen_r, rlen_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              empty_rec_r, empty_rec_nxt;
  logic [BYTE_W-1:0] key_r, key_nxt;

  logic [BYTE_W-1:0] line_r [LINE_BYTES];
  logic [BYTE_W-1:0] hist_mem [HMEM_DEPTH];
  logic [BYTE_W-1:0] hist_rd_r;
  logic [LEN_W-1:0]  hlen_mem [HISTORY_DEPTH];
  logic [LEN_W-1:0]  hlen_rd_r;

  logic              line_we, hist_we, hist_re, hlen_we, hlen_re;
  logic [LEN_W-1:0]  line_waddr;
  logic [BYTE_W-1:0] line_wdata;

  logic              up_ok, dn_ok, bs_ok, ch_ok;
  logic [CNT_W-1:0]  rp_step;
  logic [SUM_W-1:0]  slot_sum;
  logic [SLOT_W-1:0] slot_calc;
  logic [LEN_W-1:0]  lookup_len;
  logic              line_done, erase_done, text_done;

  assign up_ok = (cmd.kind == CMD_UP) && (rp_r < stored_r);
  assign dn_ok = (cmd.kind == CMD_DOWN) && (rp_r != '0);
  assign bs_ok = (cmd.kind == CMD_BACK) && (len_r != '0);
  assign ch_ok = (cmd.kind == CMD_CHAR) && (len_r != LEN_W'(LINE_BYTES - 1));

  // ring slot of the recalled line: write slot minus new depth, modulo ring size
  assign rp_step   = (cmd.kind == CMD_UP) ? rp_r + CNT_W'(1) : rp_r - CNT_W'(1);
  assign slot_sum  = SUM_W'(ws_r) + SUM_W'(HISTORY_DEPTH) - SUM_W'(rp_step);
  assign slot_calc = (slot_sum >= SUM_W'(HISTORY_DEPTH)) ?
                     SLOT_W'(slot_sum - SUM_W'(HISTORY_DEPTH)) : SLOT_W'(slot_sum);

  assign lookup_len = empty_rec_r ? '0 : hlen_rd_r;
  assign line_done  = (idx_r == len_r - LEN_W'(1));
  assign erase_done = (cnt_r == ecnt_r - LEN_W'(1));
  assign text_done  = (idx_r == rlen_r - LEN_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          if (cmd.kind == CMD_ENTER) begin
            state_nxt = ST_NL;
          end else if (bs_ok) begin
            state_nxt = ST_ERASE1;
          end else if (up_ok || dn_ok) begin
            state_nxt = ST_LOOKUP;
          end else if (ch_ok) begin
            state_nxt = ST_CHAR;
          end
        end
      end
      ST_NL: begin
        if (!res_full) begin
          state_nxt = (len_r == '0) ? ST_IDLE : ST_LINE;
        end
      end
      ST_LINE: begin
        if (!res_full && line_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERASE1: begin
        if (!res_full && erase_done) begin
          state_nxt = ST_ERASE2;
        end
      end
      ST_ERASE2: begin
        if (!res_full && erase_done) begin
          state_nxt = ST_ERASE3;
        end
      end
      ST_ERASE3: begin
        if (!res_full && erase_done) begin
          state_nxt = (rlen_r != '0) ? ST_FETCH : ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        if (len_r != '0) begin
          state_nxt = ST_ERASE1;
        end else if (lookup_len != '0) begin
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_TEXT;
      end
      ST_TEXT: begin
        if (!res_full) begin
          state_nxt = text_done ? ST_IDLE : ST_FETCH;
        end
      end
      ST_CHAR: begin
        if (!res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res        = '{out_byte: CH_BS, is_line_byte: 1'b0, line_end: 1'b0, last: 1'b0};
    line_we    = 1'b0;
    line_waddr = len_r;
    line_wdata = cmd.key;
    hist_we    = 1'b0;
    hist_re    = 1'b0;
    hlen_we    = 1'b0;
    hlen_re    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd_pop = !cmd_empty;
        hlen_re = !cmd_empty && (cmd.kind != CMD_ENTER) && (cmd.kind != CMD_BACK) &&
                  (up_ok || dn_ok);
        line_we = !cmd_empty && ch_ok;
      end
      ST_NL: begin
        res      = '{out_byte: CH_NL, is_line_byte: 1'b0,
                     line_end: (len_r == '0), last: (len_r == '0)};
        res_push = !res_full;
      end
      ST_LINE: begin
        res      = '{out_byte: line_r[idx_r], is_line_byte: 1'b1,
                     line_end: line_done, last: line_done};
        res_push = !res_full;
        hist_we  = !res_full;
        hlen_we  = !res_full && line_done;
      end
      ST_ERASE1: begin
        res_push = !res_full;
      end
      ST_ERASE2: begin
        res.out_byte = CH_SP;
        res_push     = !res_full;
      end
      ST_ERASE3: begin
        res.last = erase_done && (rlen_r == '0);
        res_push = !res_full;
      end
      ST_FETCH: begin
        hist_re = 1'b1;
      end
      ST_TEXT: begin
        res        = '{out_byte: hist_rd_r, is_line_byte: 1'b0,
                       line_end: 1'b0, last: text_done};
        res_push   = !res_full;
        line_we    = !res_full;
        line_waddr = idx_r;
        line_wdata = hist_rd_r;
      end
      ST_CHAR: begin
        res      = '{out_byte: key_r, is_line_byte: 1'b0, line_end: 1'b0, last: 1'b1};
        res_push = !res_full;
      end
      default: ;
    endcase
  end

  always_comb begin
    len_nxt       = len_r;
    ws_nxt        = ws_r;
    stored_nxt    = stored_r;
    rp_nxt        = rp_r;
    ecnt_nxt      = ecnt_r;
    cnt_nxt       = cnt_r;
    rlen_nxt      = rlen_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    empty_rec_nxt = empty_rec_r;
    key_nxt       = key_r;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          key_nxt = cmd.key;
          if (cmd.kind == CMD_ENTER) begin
            rp_nxt  = '0;
            idx_nxt = '0;
          end else if (bs_ok) begin
            len_nxt  = len_r - LEN_W'(1);
            ecnt_nxt = LEN_W'(1);
            cnt_nxt  = '0;
            rlen_nxt = '0;
          end else if (up_ok || dn_ok) begin
            rp_nxt        = rp_step;
            slot_nxt      = slot_calc;
            empty_rec_nxt = (rp_step == '0);
          end else if (ch_ok) begin
            len_nxt = len_r + LEN_W'(1);
          end
        end
      end
      ST_LINE: begin
        if (res_push) begin
          if (line_done) begin
            // commit the finished line to the ring
            ws_nxt  = (ws_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : ws_r + SLOT_W'(1);
            len_nxt = '0;
            if (stored_r != CNT_W'(HISTORY_DEPTH)) begin
              stored_nxt = stored_r + CNT_W'(1);
            end
          end else begin
            idx_nxt = idx_r + LEN_W'(1);
          end
        end
      end
      ST_ERASE1, ST_ERASE2, ST_ERASE3: begin
        if (res_push) begin
          cnt_nxt = erase_done ? '0 : cnt_r + LEN_W'(1);
        end
      end
      ST_LOOKUP: begin
        ecnt_nxt = len_r;
        len_nxt  = lookup_len;
        rlen_nxt = lookup_len;
        cnt_nxt  = '0;
        idx_nxt  = '0;
      end
      ST_TEXT: begin
        if (res_push && !text_done) begin
          idx_nxt = idx_r + LEN_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      len_r    <= '0;
      ws_r     <= '0;
      stored_r <= '0;
      rp_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      ws_r     <= ws_nxt;
      stored_r <= stored_nxt;
      rp_r     <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ecnt_r      <= ecnt_nxt;
    cnt_r       <= cnt_nxt;
    rlen_r      <= rlen_nxt;
    idx_r       <= idx_nxt;
    slot_r      <= slot_nxt;
    empty_rec_r <= empty_rec_nxt;
    key_r       <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_r[line_waddr] <= line_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[{ws_r, idx_r}] <= line_r[idx_r];
    end
    if (hist_re) begin
      hist_rd_r <= hist_mem[{slot_r, idx_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (hlen_we) begin
      hlen_mem[ws_r] <= len_r;
    end
    if (hlen_re) begin
      hlen_rd_r <= hlen_mem[slot_calc];
    end
  end

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(LINE_BYTES - 1))
    else $error("line length past capacity");
  a_recall_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rp_r <= stored_r)
    else $error("recall depth past stored lines");
  a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= CNT_W'(HISTORY_DEPTH))
    else $error("stored line count past ring size");
`endif

endmodule

### design/line_editor_with_history_top.sv
`timescale 1ns / 1ps

// Console line editor with a ring of recalled lines.
// Input queue: present a key byte on in_key_byte with in_push; it transfers
// at a clock edge where in_full is low. A two-entry command queue sits
// behind the classifier, so up to two keys can be taken while the editor works.
// Result queue: while out_empty is low the oldest result sits on out_byte,
// out_is_line_byte, out_line_end and out_last; it transfers on out_pop.
// out_last marks the final result caused by one key.
// Timing: a key passes through the registered command queue before the editor
// sees it. The result path carries one byte per cycle while the result queue
// has room; a recalled byte first waits in a fetch state for the registered
// read of the history memory, so recalled text comes out more slowly.
// A stalled result queue holds the editor in place; nothing is dropped.
// Reset (rst_n low, synchronous) empties both queues, clears the line and
// the ring, and restores the default key codes; register writes on cfg_*
// take effect at the next edge.
module line_editor_with_history_top #(
  parameter int HISTORY_DEPTH = 16,
  parameter int LINE_BYTES    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [leh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [leh_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                          in_push,
  input  logic [leh_pkg::BYTE_W-1:0]    in_key_byte,
  output logic                          in_full,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [leh_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_is_line_byte,
  output logic                          out_line_end,
  output logic                          out_last
);

  import leh_pkg::*;

  cmd_t cmd_in, cmd_q;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  res_t res_in, res_q;
  logic res_push, res_full;

  leh_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_push     (in_push),
    .in_key_byte (in_key_byte),
    .in_full     (in_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in),
    .cmd_full    (cmd_full)
  );

  leh_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_q),
    .empty (cmd_empty)
  );

  leh_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .LINE_BYTES    (LINE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_q),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  leh_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_q),
    .empty (out_empty)
  );

  assign out_byte         = res_q.out_byte;
  assign out_is_line_byte = res_q.is_line_byte;
  assign out_line_end     = res_q.line_end;
  assign out_last         = res_q.last;

endmodule
